>>> src/nbt_pkg.sv
// ---------------------------------------------------------------------------
// nbt_pkg: shared types and constants of the neighbor table
// Command, entry and result layouts, status codes and table geometry.
// ---------------------------------------------------------------------------
`default_nettype none

package nbt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int SLOT_W      = 6;
	localparam int WORD_W      = 32;
	localparam int PAYLOAD_W   = 6 * WORD_W;
	localparam int TIMEOUT_W   = 8;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd10;

	// stream widths
	localparam int IN_TDATA_W  = 264;
	localparam int OUT_TDATA_W = 264;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TUSER_W = 3;

	// command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);

	// input action codes
	localparam logic [IN_TUSER_W-1:0] ACT_UPDATE = 2'd0;
	localparam logic [IN_TUSER_W-1:0] ACT_TICK   = 2'd1;
	localparam logic [IN_TUSER_W-1:0] ACT_READ   = 2'd2;

	typedef enum logic [1:0] {
		CMD_UPDATE,
		CMD_TICK,
		CMD_READ,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  oob;       // read index beyond the table
		logic [WORD_W-1:0]     station;
		logic [SLOT_W-1:0]     slot_index;
		logic [WORD_W-1:0]     tstamp;
		logic [PAYLOAD_W-1:0]  payload;   // lat, lon, speed, heading, x, y from bit 0
	} cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0]    station;
		logic [WORD_W-1:0]    tstamp;
		logic [PAYLOAD_W-1:0] payload;
	} entry_t;

	typedef enum logic [OUT_TUSER_W-1:0] {
		STAT_UPDATED = 3'd0,
		STAT_INSERTED = 3'd1,
		STAT_FULL = 3'd2,
		STAT_BAD_ID = 3'd3,
		STAT_REMOVED = 3'd4,
		STAT_NONE = 3'd5,
		STAT_READ = 3'd6
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic              valid;
		entry_t            entry;
		logic              last;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDATA,
		S_SCAN,
		S_WRITE,
		S_DONE
	} back_state_t;

endpackage

`default_nettype wire

>>> src/nbt_front.sv
// ---------------------------------------------------------------------------
// nbt_front: input word classifier
// Unpacks an input word, sorts it into a table command and queues it.
// ---------------------------------------------------------------------------
`default_nettype none

module nbt_front (
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// station_id, slot_index, time_seconds, latitude, longitude, speed,
	// heading, x, y (lowest bit up), zero pad
	input  wire logic [nbt_pkg::IN_TDATA_W-1:0] s_tdata,
	// action
	input  wire logic [nbt_pkg::IN_TUSER_W-1:0] s_tuser,
	output logic                                q_push,
	output nbt_pkg::cmd_t                       q_data,
	input  wire logic                           q_full
);
	import nbt_pkg::*;

	logic known;

	// field unpacking
	always_comb begin
		q_data.station    = s_tdata[31:0];
		q_data.slot_index = s_tdata[37:32];
		q_data.tstamp     = s_tdata[69:38];
		q_data.payload    = s_tdata[261:70];
		q_data.oob        = {1'b0, s_tdata[37:32]} >= (SLOT_W+1)'(TABLE_DEPTH);
		known             = 1'b1;
		unique case (s_tuser)
			ACT_UPDATE: begin
				q_data.kind = (s_tdata[31:0] == '0) ? CMD_REJECT : CMD_UPDATE;
			end
			ACT_TICK: q_data.kind = CMD_TICK;
			ACT_READ: q_data.kind = CMD_READ;
			default: begin
				// unused action: taken and dropped
				q_data.kind = CMD_READ;
				known       = 1'b0;
			end
		endcase
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && known;

endmodule

`default_nettype wire

>>> src/nbt_fifo.sv
// ---------------------------------------------------------------------------
// nbt_fifo: command queue
// Short queue that decouples the classifier from the table engine.
// ---------------------------------------------------------------------------
`default_nettype none

module nbt_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire nbt_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output nbt_pkg::cmd_t      pop_data,
	output logic               not_empty
);
	import nbt_pkg::*;

	cmd_t              buf_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = count_q == (QPTR_W+1)'(Q_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = buf_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

>>> src/nbt_back.sv
// ---------------------------------------------------------------------------
// nbt_back: table engine
// Holds the entry memory and valid bits, walks the table for updates and
// aging ticks, and drives the result stream through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module nbt_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_valid,
	input  wire nbt_pkg::cmd_t                   cmd,
	output logic                                 cmd_pop,
	input  wire logic                            timeout_we,
	input  wire logic [nbt_pkg::TIMEOUT_W-1:0]   timeout_wdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// slot, entry_valid, entry_station, entry_time, entry_latitude,
	// entry_longitude, entry_speed, entry_heading, entry_x, entry_y, zero pad
	output logic [nbt_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// status
	output logic [nbt_pkg::OUT_TUSER_W-1:0]      m_tuser,
	output logic                                 m_tlast
);
	import nbt_pkg::*;

	back_state_t            state_q, state_d;
	cmd_t                   cmd_q, cmd_d;
	logic                   issue_live_q, issue_live_d;
	logic [IDX_W-1:0]       issue_idx_q, issue_idx_d;
	logic                   cmp_live_q, cmp_live_d;
	logic [IDX_W-1:0]       cmp_idx_q, cmp_idx_d;
	logic                   free_found_q, free_found_d;
	logic [IDX_W-1:0]       free_idx_q, free_idx_d;
	logic [IDX_W-1:0]       tgt_q, tgt_d;
	logic                   hit_q, hit_d;
	logic                   pend_valid_q, pend_valid_d;
	res_t                   pend_q, pend_d;
	logic                   out_valid_q;
	res_t                   out_q;
	logic [TABLE_DEPTH-1:0] valid_q, valid_d;
	logic [TIMEOUT_W-1:0]   timeout_q;

	entry_t                 mem_q [TABLE_DEPTH];
	entry_t                 rd_data_q;
	logic                   rd_en, wr_en;
	logic [IDX_W-1:0]       rd_addr;

	logic                   out_free, push, stall, aged, hit;
	res_t                   push_res;
	entry_t                 cmd_entry;

	assign out_free  = !out_valid_q || m_tready;
	assign cmd_entry = '{station: cmd_q.station, tstamp: cmd_q.tstamp,
		payload: cmd_q.payload};

	// compare stage of the walk: match and age of the slot just read
	assign hit  = valid_q[cmp_idx_q] && (rd_data_q.station == cmd_q.station);
	assign aged = valid_q[cmp_idx_q] && (cmd_q.tstamp > rd_data_q.tstamp)
		&& ((cmd_q.tstamp - rd_data_q.tstamp) > {{(WORD_W-TIMEOUT_W){1'b0}}, timeout_q});
	assign stall = (state_q == S_SCAN) && cmp_live_q && (cmd_q.kind == CMD_TICK)
		&& aged && pend_valid_q && !out_free;

	// sequencer
	always_comb begin
		state_d      = state_q;
		cmd_d        = cmd_q;
		issue_live_d = issue_live_q;
		issue_idx_d  = issue_idx_q;
		cmp_live_d   = cmp_live_q;
		cmp_idx_d    = cmp_idx_q;
		free_found_d = free_found_q;
		free_idx_d   = free_idx_q;
		tgt_d        = tgt_q;
		hit_d        = hit_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		valid_d      = valid_q;
		cmd_pop      = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = issue_idx_q;
		wr_en        = 1'b0;
		push         = 1'b0;
		push_res     = '0;
		push_res.last = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_REJECT: begin
							if (out_free) begin
								push            = 1'b1;
								push_res.status = STAT_BAD_ID;
								cmd_pop         = 1'b1;
							end
						end
						CMD_READ: begin
							if (cmd.oob) begin
								// beyond the table: answered as an empty slot
								if (out_free) begin
									push            = 1'b1;
									push_res.status = STAT_READ;
									push_res.slot   = cmd.slot_index;
									cmd_pop         = 1'b1;
								end
							end else begin
								rd_en   = 1'b1;
								rd_addr = cmd.slot_index[IDX_W-1:0];
								cmd_pop = 1'b1;
								cmd_d   = cmd;
								state_d = S_RDATA;
							end
						end
						CMD_UPDATE, CMD_TICK: begin
							cmd_pop      = 1'b1;
							cmd_d        = cmd;
							issue_live_d = 1'b1;
							issue_idx_d  = '0;
							cmp_live_d   = 1'b0;
							free_found_d = 1'b0;
							pend_valid_d = 1'b0;
							state_d      = S_SCAN;
						end
						default: ;
					endcase
				end
			end
			S_RDATA: begin
				if (out_free) begin
					push            = 1'b1;
					push_res.status = STAT_READ;
					push_res.slot   = cmd_q.slot_index;
					push_res.valid  = valid_q[cmd_q.slot_index[IDX_W-1:0]];
					if (valid_q[cmd_q.slot_index[IDX_W-1:0]]) push_res.entry = rd_data_q;
					state_d         = S_IDLE;
				end
			end
			S_SCAN: begin
				if (!issue_live_q && !cmp_live_q) begin
					// walk finished
					if (cmd_q.kind == CMD_UPDATE && free_found_q) begin
						tgt_d   = free_idx_q;
						hit_d   = 1'b0;
						state_d = S_WRITE;
					end else begin
						state_d = S_DONE;
					end
				end else if (!stall) begin
					// read stage
					if (issue_live_q) begin
						rd_en      = 1'b1;
						cmp_live_d = 1'b1;
						cmp_idx_d  = issue_idx_q;
						if (issue_idx_q == IDX_W'(TABLE_DEPTH - 1)) issue_live_d = 1'b0;
						else issue_idx_d = issue_idx_q + 1'b1;
					end else begin
						cmp_live_d = 1'b0;
					end
					// compare stage
					if (cmp_live_q) begin
						if (cmd_q.kind == CMD_UPDATE) begin
							if (hit) begin
								tgt_d        = cmp_idx_q;
								hit_d        = 1'b1;
								issue_live_d = 1'b0;
								cmp_live_d   = 1'b0;
								state_d      = S_WRITE;
							end else if (!valid_q[cmp_idx_q] && !free_found_q) begin
								free_found_d = 1'b1;
								free_idx_d   = cmp_idx_q;
							end
						end else if (aged) begin
							// a removal is held until the next one or the end of the walk, so its last flag is known
							if (pend_valid_q) begin
								push     = 1'b1;
								push_res = pend_q;
							end
							pend_valid_d       = 1'b1;
							pend_d             = '0;
							pend_d.status      = STAT_REMOVED;
							pend_d.slot        = SLOT_W'(cmp_idx_q);
							pend_d.entry       = rd_data_q;
							valid_d[cmp_idx_q] = 1'b0;
						end
					end
				end
			end
			S_WRITE: begin
				if (out_free) begin
					wr_en           = 1'b1;
					valid_d[tgt_q]  = 1'b1;
					push            = 1'b1;
					push_res.status = hit_q ? STAT_UPDATED : STAT_INSERTED;
					push_res.slot   = SLOT_W'(tgt_q);
					push_res.valid  = 1'b1;
					push_res.entry  = cmd_entry;
					state_d         = S_IDLE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					push = 1'b1;
					if (cmd_q.kind == CMD_UPDATE) begin
						push_res.status = STAT_FULL;
					end else if (pend_valid_q) begin
						push_res      = pend_q;
						push_res.last = 1'b1;
					end else begin
						push_res.status = STAT_NONE;
					end
					pend_valid_d = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issue_live_q <= 1'b0;
			cmp_live_q   <= 1'b0;
			free_found_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			valid_q      <= '0;
			timeout_q    <= TIMEOUT_RESET;
		end else begin
			state_q      <= state_d;
			issue_live_q <= issue_live_d;
			cmp_live_q   <= cmp_live_d;
			free_found_q <= free_found_d;
			pend_valid_q <= pend_valid_d;
			valid_q      <= valid_d;
			if (push)          out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (timeout_we) timeout_q <= timeout_wdata;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		issue_idx_q <= issue_idx_d;
		cmp_idx_q   <= cmp_idx_d;
		free_idx_q  <= free_idx_d;
		tgt_q       <= tgt_d;
		hit_q       <= hit_d;
		pend_q      <= pend_d;
		if (push) out_q <= push_res;
	end

	// entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[tgt_q] <= cmd_entry;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	// result stream
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.entry.payload, out_q.entry.tstamp, out_q.entry.station,
		out_q.valid, out_q.slot};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

	// checks
	a_remove_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && cmp_live_q && cmd_q.kind == CMD_TICK && aged && !stall)
		|=> !valid_q[$past(cmp_idx_q)])
		else $error("aged entry still valid after removal");

	a_write_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && out_free) |=> valid_q[$past(tgt_q)])
		else $error("written slot not marked valid");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == S_IDLE && cmd_valid))
		else $error("command taken while busy");

	a_pend_scope: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q == S_SCAN || state_q == S_DONE))
		else $error("pending removal outside a tick");

endmodule

`default_nettype wire

>>> src/neighbor_table_with_aging.sv
// A read answers once its slot is read and the result registered. An update or
// a tick walks the slots through the single read port of the entry memory, one
// slot per cycle while no removal waits on a stalled output; an update stops at
// a matching station. The engine takes the next command only when it is idle.
// Reset clears all valid bits at once and sets the timeout to 10; no
// clearing pass, the block takes words right after reset.
// ---------------------------------------------------------------------------
// neighbor_table_with_aging: keyed station table with timeout aging
// Classifier, command queue and table engine on a stream interface.
// ---------------------------------------------------------------------------
`default_nettype none

module neighbor_table_with_aging (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// station_id, slot_index, time_seconds, latitude, longitude, speed,
	// heading, x, y (lowest bit up), zero pad
	input  wire logic [nbt_pkg::IN_TDATA_W-1:0]  s_tdata,
	// action
	input  wire logic [nbt_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// slot, entry_valid, entry_station, entry_time, entry_latitude,
	// entry_longitude, entry_speed, entry_heading, entry_x, entry_y, zero pad
	output logic [nbt_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// status
	output logic [nbt_pkg::OUT_TUSER_W-1:0]      m_tuser,
	output logic                                 m_tlast,
	input  wire logic                            timeout_we,
	input  wire logic [nbt_pkg::TIMEOUT_W-1:0]   timeout_wdata
);
	import nbt_pkg::*;

	logic q_push, q_full, q_pop, q_not_empty;
	cmd_t q_in, q_out;

	nbt_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_push   (q_push),
		.q_data   (q_in),
		.q_full   (q_full)
	);

	nbt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.not_empty (q_not_empty)
	);

	nbt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (q_not_empty),
		.cmd           (q_out),
		.cmd_pop       (q_pop),
		.timeout_we    (timeout_we),
		.timeout_wdata (timeout_wdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast)
	);

endmodule

`default_nettype wire
